// File: src/rls_pkg.sv
// ----------------------------------------------------------------------------
// rls_pkg - shared definitions for the reversible LIFO stack
// Operation, status and read-select codes, field widths and the stage record.
// ----------------------------------------------------------------------------
package rls_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int DATA_W    = 32;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 5;
    localparam int S_TDATA_W = DATA_W;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = STATUS_W + 1;
    localparam int PAD_W     = M_TDATA_W - DATA_W - COUNT_W;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUSH    = 2'd0;
    localparam logic [OP_W-1:0] OP_POP     = 2'd1;
    localparam logic [OP_W-1:0] OP_PEEK    = 2'd2;
    localparam logic [OP_W-1:0] OP_REVERSE = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Source of the read value
    localparam logic [1:0] RD_ZERO   = 2'd0;
    localparam logic [1:0] RD_MEM    = 2'd1;
    localparam logic [1:0] RD_NEG1   = 2'd2;
    localparam logic [1:0] RD_NEG128 = 2'd3;

    localparam logic [DATA_W-1:0] NEG1_WORD   = 32'hFFFF_FFFF;
    localparam logic [DATA_W-1:0] NEG128_WORD = 32'hFFFF_FF80;

    typedef struct packed {
        logic [1:0]          rd_sel;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  entry_count;
        logic                now_empty;
    } rls_meta_t;

endpackage

// File: src/rls_ctrl.sv
// ----------------------------------------------------------------------------
// rls_ctrl - pointer and count control
// Decodes each operation, updates base, count and direction, drives the store.
// ----------------------------------------------------------------------------
module rls_ctrl #(
    parameter int DEPTH = rls_pkg::DEPTH_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic [rls_pkg::OP_W-1:0]   operation,
    input  logic                       advance,
    output logic                       wr_en,
    output logic [$clog2(DEPTH)-1:0]   wr_addr,
    output logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic                       stage_valid_reg,
    output rls_pkg::rls_meta_t         meta_reg
);
    import rls_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

    logic [AW-1:0] base_reg, base_next;
    logic [CW-1:0] count_reg, count_next;
    logic          rev_reg, rev_next;
    logic          stage_valid_next;
    rls_meta_t     meta_next;

    logic          stack_empty, is_full;
    logic [SW-1:0] sum_bc;
    logic [AW-1:0] up_slot, top_norm, base_dn, base_up;

    always_comb
    begin
        stack_empty = (count_reg == '0);
        is_full     = (count_reg == DEPTH_C);
        sum_bc      = SW'(base_reg) + SW'(count_reg);
        // Slot just above the highest occupied one, wrapped once.
        up_slot  = (sum_bc >= DEPTH_S) ? AW'(sum_bc - DEPTH_S) : AW'(sum_bc);
        top_norm = (up_slot == '0) ? LAST_A : up_slot - 1'b1;
        base_dn  = (base_reg == '0) ? LAST_A : base_reg - 1'b1;
        base_up  = (base_reg == LAST_A) ? '0 : base_reg + 1'b1;

        rd_addr  = rev_reg ? base_reg : top_norm;
        wr_addr  = rev_reg ? base_dn : up_slot;

        wr_en      = 1'b0;
        base_next  = base_reg;
        count_next = count_reg;
        rev_next   = rev_reg;
        meta_next.rd_sel = RD_ZERO;
        meta_next.status = ST_OK;

        case (operation)
            OP_PUSH:
            begin
                if (is_full)
                begin
                    meta_next.status = ST_FULL;
                end
                else
                begin
                    wr_en      = accept;
                    base_next  = rev_reg ? base_dn : base_reg;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_POP:
            begin
                if (stack_empty)
                begin
                    meta_next.rd_sel = RD_NEG1;
                    meta_next.status = ST_EMPTY;
                end
                else
                begin
                    meta_next.rd_sel = RD_MEM;
                    base_next  = rev_reg ? base_up : base_reg;
                    count_next = count_reg - 1'b1;
                end
            end
            OP_PEEK:
            begin
                if (stack_empty)
                begin
                    meta_next.rd_sel = RD_NEG128;
                    meta_next.status = ST_EMPTY;
                end
                else
                begin
                    meta_next.rd_sel = RD_MEM;
                end
            end
            default:
            begin
                rev_next = !rev_reg;
            end
        endcase

        meta_next.entry_count = COUNT_W'(count_next);
        meta_next.now_empty   = (count_next == '0);

        if (accept)
            stage_valid_next = 1'b1;
        else if (advance)
            stage_valid_next = 1'b0;
        else
            stage_valid_next = stage_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg        <= '0;
            count_reg       <= '0;
            rev_reg         <= 1'b0;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            if (accept)
            begin
                base_reg  <= base_next;
                count_reg <= count_next;
                rev_reg   <= rev_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            meta_reg <= meta_next;
    end

endmodule

// File: src/rls_mem.sv
// ----------------------------------------------------------------------------
// rls_mem - word store
// One write port and one read port with a registered read word.
// ----------------------------------------------------------------------------
module rls_mem #(
    parameter int DEPTH = rls_pkg::DEPTH_DEFAULT
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [$clog2(DEPTH)-1:0]    wr_addr,
    input  logic [rls_pkg::DATA_W-1:0]  wr_data,
    input  logic                        rd_en,
    input  logic [$clog2(DEPTH)-1:0]    rd_addr,
    output logic [rls_pkg::DATA_W-1:0]  rd_data_reg
);
    import rls_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

endmodule

// File: src/rls_ostage.sv
// ----------------------------------------------------------------------------
// rls_ostage - result register
// Forms the result beat and holds it until the receiver takes it.
// ----------------------------------------------------------------------------
module rls_ostage (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           stage_valid,
    input  rls_pkg::rls_meta_t             meta,
    input  logic [rls_pkg::DATA_W-1:0]     rd_data,
    output logic                           advance,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [rls_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [rls_pkg::M_TUSER_W-1:0]  m_tuser
);
    import rls_pkg::*;

    logic                 out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] tdata_reg;
    logic [M_TUSER_W-1:0] tuser_reg;
    logic [DATA_W-1:0]    read_value;

    always_comb
    begin
        advance = stage_valid && (!out_valid_reg || m_tready);

        case (meta.rd_sel)
            RD_MEM:    read_value = rd_data;
            RD_NEG1:   read_value = NEG1_WORD;
            RD_NEG128: read_value = NEG128_WORD;
            default:   read_value = '0;
        endcase

        if (advance)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tdata_reg <= {{PAD_W{1'b0}}, meta.entry_count, read_value};
            tuser_reg <= {meta.now_empty, meta.status};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;

endmodule

// File: src/reversible_lifo_stack.sv
// ----------------------------------------------------------------------------
// reversible_lifo_stack - bounded LIFO of signed words with in-place reverse
// Push, pop, peek and reverse over a circular store, one result beat per beat.
// ----------------------------------------------------------------------------
// Usage:
// Each input beat on the s_ channel carries one operation in s_tuser and the
// word to push in s_tdata. Each accepted beat yields exactly one result beat
// on the m_ channel: the popped or peeked word, a status code, the entry
// count after the operation and an empty flag.
// Reverse only flips which end of the occupied run is the top, so it costs
// the same as any other operation.
// On acceptance the pointers update, the store is read or written and the
// middle stage is loaded; the result register then loads from it when free.
// Throughput is one beat per cycle unless the receiver stalls; the single
// read and write port of the store is used at most once per beat.
// A stalled receiver holds the result register; one further beat is still
// taken into the middle stage before s_tready falls.
// Reset clears the base index, the count, the direction flag and all valid
// state. The store itself is not cleared, as only written entries are read,
// so there is no clearing pass and beats are taken straight after reset.
// ----------------------------------------------------------------------------
module reversible_lifo_stack #(
    parameter int DEPTH = rls_pkg::DEPTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rls_pkg::S_TDATA_W-1:0] s_tdata,   // [31:0] push_value
    input  logic [rls_pkg::OP_W-1:0]      s_tuser,   // [1:0] operation
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rls_pkg::M_TDATA_W-1:0] m_tdata,   // [31:0] read_value,
                                                     // [36:32] entry_count
    output logic [rls_pkg::M_TUSER_W-1:0] m_tuser    // [1:0] status,
                                                     // [2] now_empty
);
    import rls_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic          accept;
    logic          advance;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic          stage_valid;
    rls_meta_t     meta;
    logic [DATA_W-1:0] rd_data;

    // The middle stage may take a beat whenever it is empty or draining.
    assign s_tready = !stage_valid || advance;
    assign accept   = s_tvalid && s_tready;

    rls_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .operation       (s_tuser),
        .advance         (advance),
        .wr_en           (wr_en),
        .wr_addr         (wr_addr),
        .rd_addr         (rd_addr),
        .stage_valid_reg (stage_valid),
        .meta_reg        (meta)
    );

    // The read word is captured only on acceptance, so it holds while the
    // middle stage waits for the result register.
    rls_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .clk         (clk),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (s_tdata),
        .rd_en       (accept),
        .rd_addr     (rd_addr),
        .rd_data_reg (rd_data)
    );

    rls_ostage u_ostage (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_valid (stage_valid),
        .meta        (meta),
        .rd_data     (rd_data),
        .advance     (advance),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

// File: src/rls_checker.sv
// ----------------------------------------------------------------------------
// rls_checker - port-level checks for the reversible LIFO stack
// Consistency of result beats and stall behaviour, bound to the top level.
// ----------------------------------------------------------------------------
module rls_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [rls_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [rls_pkg::M_TUSER_W-1:0] m_tuser
);
    import rls_pkg::*;

    // An empty stack always reports a zero count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[2]) |-> (m_tdata[36:32] == '0))
    else $error("empty flag with non-zero count");

    // A dropped push means the stack was full, so it cannot be empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1:0] == ST_FULL) |-> (!m_tuser[2] && m_tdata[31:0] == '0))
    else $error("full status with empty stack or non-zero word");

    // An empty pop or peek leaves the stack empty and returns a marker word.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1:0] == ST_EMPTY) |->
        (m_tuser[2] && (m_tdata[31:0] == NEG1_WORD || m_tdata[31:0] == NEG128_WORD)))
    else $error("empty status with wrong word or flag");

    // A stalled result beat holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result beat changed");

endmodule

bind reversible_lifo_stack rls_checker u_rls_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
